// ----- hw/rtl/lspp_pkg.sv -----
// Package for the lidar scan packet parser: widths, header and kind codes,
// byte positions, controller state type and the controller/datapath structs.
// Depends on nothing; every other file of the parser uses it.
`timescale 1ns / 1ps

package lspp_pkg;

  // Default number of fraction bits kept below 1/64 degree in the angle math.
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 8;

  // Field widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned ANGLE_W = 15;
  localparam int unsigned RPM_W   = 10;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned WORD_W  = 16;

  // Header bytes and the header word folded into the checksum.
  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
  localparam logic [WORD_W-1:0] HEADER_WORD = 16'h55AA;

  // One full turn in 1/64 degree (360 * 64).
  localparam logic [WORD_W-1:0] FULL_TURN = 16'd23040;

  // Type byte: bit zero flags rate info, the upper bits give rate / 6.
  localparam int unsigned       RPM_FLAG_BIT = 0;
  localparam logic [RPM_W-1:0]  RPM_SCALE    = 10'd6;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_POINT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END_GOOD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_BAD  = 2'd2;

  // Byte positions inside a frame (header is positions 0 to 3).
  localparam logic [POS_W-1:0] POS_BODY_FIRST = 10'd4;
  localparam logic [POS_W-1:0] POS_START_HI   = 10'd5;
  localparam logic [POS_W-1:0] POS_END_HI     = 10'd7;
  localparam logic [POS_W-1:0] POS_CHECK_HI   = 10'd9;
  // Bytes after the count byte that are not samples: three words.
  localparam logic [POS_W-1:0] BODY_FIXED_BYTES = 10'd6;

  // Controller states.
  typedef enum logic [2:0] {
    ST_HUNT_FIRST,
    ST_HUNT_SECOND,
    ST_TYPE,
    ST_COUNT,
    ST_BODY,
    ST_DIVIDE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_type;
    logic take_count;
    logic take_body;
    logic div_start;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sync_first_hit;
    logic sync_second_hit;
    logic end_word;
    logic frame_last;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/lspp_if.sv -----
// Channel interfaces of the lidar scan packet parser: byte input, result
// output and enable write channel. Depends on lspp_pkg for field widths.
`timescale 1ns / 1ps

// Serial byte channel.
interface lspp_in_if;
  logic                         valid;
  logic                         ready;
  logic [lspp_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Point and frame status channel.
interface lspp_out_if;
  logic                         valid;
  logic                         ready;
  logic [lspp_pkg::KIND_W-1:0]  kind;
  logic [lspp_pkg::DIST_W-1:0]  distance;
  logic [lspp_pkg::ANGLE_W-1:0] angle;
  logic [lspp_pkg::RPM_W-1:0]   rpm;
  logic                         rpm_valid;
  logic [lspp_pkg::COUNT_W-1:0] point_count;
  logic                         last;

  modport source (output valid, output kind, output distance, output angle, output rpm,
                  output rpm_valid, output point_count, output last, input ready);
  modport sink   (input valid, input kind, input distance, input angle, input rpm,
                  input rpm_valid, input point_count, input last, output ready);
endinterface

// Enable register write channel.
interface lspp_cfg_if;
  logic valid;
  logic ready;
  logic enable;

  modport source (output valid, output enable, input ready);
  modport sink   (input valid, input enable, output ready);
endinterface

// ----- hw/rtl/lspp_divider.sv -----
// Restoring divider, one quotient bit per cycle, used for the angle step.
// Depends on lspp_pkg for the divisor width.
`timescale 1ns / 1ps

module lspp_divider #(
  parameter int unsigned DIVIDEND_W = 23
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DIVIDEND_W-1:0]       dividend_i,
  input  logic [lspp_pkg::BYTE_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [DIVIDEND_W-1:0]       quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);
  localparam int unsigned DVS_W = lspp_pkg::BYTE_W;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0]      rem_q, rem_d;
  logic [DVS_W-1:0]      dvs_q, dvs_d;
  logic [DVS_W:0]        trial;
  logic [DVS_W:0]        trial_diff;
  logic                  quo_bit;

  // One shift-and-subtract step per cycle, dividend bits shifted out at the top.
  always_comb begin
    trial      = {rem_q, quo_q[DIVIDEND_W-1]};
    trial_diff = trial - {1'b0, dvs_q};
    quo_bit    = (trial >= {1'b0, dvs_q});
    cnt_d      = cnt_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    dvs_d      = dvs_q;
    done_d     = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CNT_W'(DIVIDEND_W);
    end else if (cnt_q != '0) begin
      rem_d  = quo_bit ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_d  = {quo_q[DIVIDEND_W-2:0], quo_bit};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  // Step counter and done flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/lspp_datapath.sv -----
// Datapath of the packet parser: frame registers, checksum, angle
// interpolation, step divider and the result register.
// Depends on lspp_pkg and lspp_divider.
`timescale 1ns / 1ps

module lspp_datapath #(
  parameter int unsigned ANGLE_FRAC_BITS = lspp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lspp_pkg::BYTE_W-1:0]  data_byte_i,
  input  lspp_pkg::ctrl_cmd_t          cmd_i,
  output lspp_pkg::dp_status_t         status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lspp_pkg::KIND_W-1:0]  out_kind_o,
  output logic [lspp_pkg::DIST_W-1:0]  out_distance_o,
  output logic [lspp_pkg::ANGLE_W-1:0] out_angle_o,
  output logic [lspp_pkg::RPM_W-1:0]   out_rpm_o,
  output logic                         out_rpm_valid_o,
  output logic [lspp_pkg::COUNT_W-1:0] out_point_count_o,
  output logic                         out_last_o
);

  localparam int unsigned F      = ANGLE_FRAC_BITS;
  localparam int unsigned STEP_W = lspp_pkg::ANGLE_W + F;
  localparam int unsigned ACC_W  = lspp_pkg::WORD_W + F;
  localparam int unsigned SUM_W  = ACC_W + 1;
  localparam int unsigned POS_W  = lspp_pkg::POS_W;
  localparam int unsigned BYTE_W = lspp_pkg::BYTE_W;
  localparam int unsigned WORD_W = lspp_pkg::WORD_W;
  localparam int unsigned DIFF_W = lspp_pkg::ANGLE_W + 2;

  localparam logic [SUM_W-1:0] TURN_LIMIT =
    {{(SUM_W - WORD_W){1'b0}}, lspp_pkg::FULL_TURN} << F;

  // Frame registers.
  logic [POS_W-1:0]             pos_q, pos_d;
  logic [POS_W-1:0]             remain_q, remain_d;
  logic [lspp_pkg::COUNT_W-1:0] count_q, count_d;
  logic [BYTE_W-1:0]            type_q, type_d;
  logic [BYTE_W-1:0]            low_q, low_d;
  logic [WORD_W-1:0]            xor_q, xor_d;
  logic [WORD_W-1:0]            check_q, check_d;
  logic [lspp_pkg::ANGLE_W-1:0] start_q, start_d;
  logic [STEP_W-1:0]            step_q, step_d;
  logic [ACC_W-1:0]             acc_q, acc_d;

  // Result register.
  logic                         out_valid_q, out_valid_d;
  logic [lspp_pkg::KIND_W-1:0]  kind_q, kind_d;
  logic [lspp_pkg::DIST_W-1:0]  dist_q, dist_d;
  logic [lspp_pkg::ANGLE_W-1:0] angle_q, angle_d;
  logic [lspp_pkg::RPM_W-1:0]   rpm_q, rpm_d;
  logic                         rpm_valid_q, rpm_valid_d;
  logic [lspp_pkg::COUNT_W-1:0] pcount_q, pcount_d;
  logic                         last_q, last_d;

  logic [WORD_W-1:0]            word;
  logic [lspp_pkg::ANGLE_W-1:0] end_angle;
  logic [DIFF_W-1:0]            diff_raw;
  logic [DIFF_W-1:0]            diff_wrap;
  logic [lspp_pkg::ANGLE_W-1:0] diff;
  logic [STEP_W-1:0]            dividend;
  logic [BYTE_W-1:0]            divisor;
  logic                         div_done;
  logic [STEP_W-1:0]            quotient;
  logic [SUM_W-1:0]             acc_sum;
  logic [SUM_W-1:0]             acc_wrapped;
  logic                         is_point;
  logic                         is_last;
  logic                         good;
  logic                         rate_ok;

  assign word      = {data_byte_i, low_q};
  assign end_angle = word[WORD_W-1:1];

  // Angle span from start to end, wrapped once by a full turn, zero if still negative.
  always_comb begin
    diff_raw  = {2'b00, end_angle} - {2'b00, start_q};
    diff_wrap = diff_raw + DIFF_W'(lspp_pkg::FULL_TURN);
    diff      = '0;
    if (!diff_raw[DIFF_W-1]) begin
      diff = diff_raw[lspp_pkg::ANGLE_W-1:0];
    end else if (!diff_wrap[DIFF_W-1]) begin
      diff = diff_wrap[lspp_pkg::ANGLE_W-1:0];
    end
  end

  assign dividend = {diff, {F{1'b0}}};
  assign divisor  = count_q - 1'b1;

  lspp_divider #(
    .DIVIDEND_W (STEP_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Next accumulator value: add the step, take one turn off when past it.
  always_comb begin
    acc_sum     = {1'b0, acc_q} + SUM_W'(step_q);
    acc_wrapped = (acc_sum > TURN_LIMIT) ? (acc_sum - TURN_LIMIT) : acc_sum;
  end

  // Header loads and body byte handling.
  always_comb begin
    pos_d       = pos_q;
    remain_d    = remain_q;
    count_d     = count_q;
    type_d      = type_q;
    low_d       = low_q;
    xor_d       = xor_q;
    check_d     = check_q;
    start_d     = start_q;
    step_d      = step_q;
    acc_d       = acc_q;
    is_point    = 1'b0;
    is_last     = 1'b0;

    if (cmd_i.take_type) begin
      type_d = data_byte_i;
    end
    if (cmd_i.take_count) begin
      count_d  = data_byte_i;
      remain_d = lspp_pkg::BODY_FIXED_BYTES + {1'b0, data_byte_i, 1'b0};
      xor_d    = lspp_pkg::HEADER_WORD ^ {data_byte_i, type_q};
      pos_d    = lspp_pkg::POS_BODY_FIRST;
    end
    if (div_done) begin
      step_d = (count_q[lspp_pkg::COUNT_W-1:1] == '0) ? '0 : quotient;
    end
    if (cmd_i.take_body) begin
      priority if (!pos_q[0]) begin
        low_d = data_byte_i;
      end else if (pos_q == lspp_pkg::POS_START_HI) begin
        start_d = end_angle;
        xor_d   = xor_q ^ word;
      end else if (pos_q == lspp_pkg::POS_END_HI) begin
        xor_d = xor_q ^ word;
        acc_d = ACC_W'(start_q) << F;
      end else if (pos_q == lspp_pkg::POS_CHECK_HI) begin
        check_d = word;
      end else begin
        xor_d    = xor_q ^ word;
        is_point = 1'b1;
        acc_d    = acc_wrapped[ACC_W-1:0];
      end
      pos_d    = pos_q + 1'b1;
      remain_d = remain_q - 1'b1;
      is_last  = (remain_q == POS_W'(1));
    end
  end

  assign good    = (xor_d == check_d);
  assign rate_ok = good && type_q[lspp_pkg::RPM_FLAG_BIT];

  // Result register: loaded by a point or by the frame's last byte.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    dist_d      = dist_q;
    angle_d     = angle_q;
    rpm_d       = rpm_q;
    rpm_valid_d = rpm_valid_q;
    pcount_d    = pcount_q;
    last_d      = last_q;
    if (is_point || is_last) begin
      out_valid_d = 1'b1;
      dist_d      = is_point ? word[WORD_W-1:2] : '0;
      angle_d     = is_point ? acc_q[F +: lspp_pkg::ANGLE_W] : '0;
      kind_d      = lspp_pkg::KIND_POINT;
      rpm_d       = '0;
      rpm_valid_d = 1'b0;
      pcount_d    = '0;
      last_d      = is_last;
      if (is_last) begin
        kind_d      = good ? lspp_pkg::KIND_END_GOOD : lspp_pkg::KIND_END_BAD;
        rpm_d       = rate_ok ? (lspp_pkg::RPM_W'(type_q[BYTE_W-1:1]) * lspp_pkg::RPM_SCALE)
                              : '0;
        rpm_valid_d = rate_ok;
        pcount_d    = count_q;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Frame and result payload registers.
  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    type_q      <= type_d;
    low_q       <= low_d;
    xor_q       <= xor_d;
    check_q     <= check_d;
    start_q     <= start_d;
    step_q      <= step_d;
    acc_q       <= acc_d;
    kind_q      <= kind_d;
    dist_q      <= dist_d;
    angle_q     <= angle_d;
    rpm_q       <= rpm_d;
    rpm_valid_q <= rpm_valid_d;
    pcount_q    <= pcount_d;
    last_q      <= last_d;
  end

  // Status toward the controller.
  assign status_o.sync_first_hit  = (data_byte_i == lspp_pkg::SYNC_FIRST);
  assign status_o.sync_second_hit = (data_byte_i == lspp_pkg::SYNC_SECOND);
  assign status_o.end_word        = (pos_q == lspp_pkg::POS_END_HI);
  assign status_o.frame_last      = (remain_q == POS_W'(1));
  assign status_o.div_done        = div_done;
  assign status_o.out_free        = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = kind_q;
  assign out_distance_o    = dist_q;
  assign out_angle_o       = angle_q;
  assign out_rpm_o         = rpm_q;
  assign out_rpm_valid_o   = rpm_valid_q;
  assign out_point_count_o = pcount_q;
  assign out_last_o        = last_q;

endmodule

// ----- hw/rtl/lspp_ctrl.sv -----
// Controller of the packet parser: enable register, header hunt and
// frame sequencing, input handshake and datapath commands. Depends on lspp_pkg.
`timescale 1ns / 1ps

module lspp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_enable_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lspp_pkg::dp_status_t status_i,
  output lspp_pkg::ctrl_cmd_t  cmd_o
);

  lspp_pkg::ctrl_state_e state_q, state_d;
  logic                  enable_q, enable_d;
  logic                  take;

  // Enable register, written from the configuration channel.
  assign enable_d = cfg_valid_i ? cfg_enable_i : enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lspp_pkg::ST_HUNT_FIRST;
      enable_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      enable_q <= enable_d;
    end
  end

  // Next state and commands; a word is taken only while the result slot is free.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q != lspp_pkg::ST_DIVIDE) && status_i.out_free;
    take       = in_valid_i && in_ready_o;

    unique case (state_q)
      lspp_pkg::ST_HUNT_FIRST: begin
        if (take && enable_q && status_i.sync_first_hit) begin
          state_d = lspp_pkg::ST_HUNT_SECOND;
        end
      end
      lspp_pkg::ST_HUNT_SECOND: begin
        if (take) begin
          state_d = status_i.sync_second_hit ? lspp_pkg::ST_TYPE : lspp_pkg::ST_HUNT_FIRST;
        end
      end
      lspp_pkg::ST_TYPE: begin
        if (take) begin
          cmd_o.take_type = 1'b1;
          state_d         = lspp_pkg::ST_COUNT;
        end
      end
      lspp_pkg::ST_COUNT: begin
        if (take) begin
          cmd_o.take_count = 1'b1;
          state_d          = lspp_pkg::ST_BODY;
        end
      end
      lspp_pkg::ST_BODY: begin
        if (take) begin
          cmd_o.take_body = 1'b1;
          if (status_i.frame_last) begin
            state_d = lspp_pkg::ST_HUNT_FIRST;
          end else if (status_i.end_word) begin
            cmd_o.div_start = 1'b1;
            state_d         = lspp_pkg::ST_DIVIDE;
          end
        end
      end
      lspp_pkg::ST_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = lspp_pkg::ST_BODY;
        end
      end
      default: begin
        state_d = lspp_pkg::ST_HUNT_FIRST;
      end
    endcase

    // A disabled parser swallows the word and goes back to the hunt.
    if (take && !enable_q) begin
      cmd_o   = '0;
      state_d = lspp_pkg::ST_HUNT_FIRST;
    end
  end

endmodule

// ----- hw/rtl/lidar_scan_packet_parser_unit.sv -----
// Top level of the lidar scan packet parser: joins the controller and the
// datapath to the channel interfaces. Depends on lspp_pkg, lspp_if.sv,
// lspp_ctrl and lspp_datapath.
//
//   channel  direction  payload                                        handshake
//   cfg_i    in         enable                                         valid/ready
//   in_i     in         data_byte                                      valid/ready
//   out_o    out        kind, distance, angle, rpm, rpm_valid,         valid/ready
//                       point_count, last
//
// Results go to an output register, and a byte is taken only while that
// register is empty or being read out.
// The end angle word starts the angle step division, which runs one quotient
// bit per cycle over 15 + ANGLE_FRAC_BITS steps; input is held off until the
// division is done and its step is taken over.
// Reset puts the parser in header hunt, disabled, with the output register empty.
`timescale 1ns / 1ps

module lidar_scan_packet_parser_unit #(
  parameter int unsigned ANGLE_FRAC_BITS = lspp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lspp_cfg_if.sink      cfg_i,
  lspp_in_if.sink       in_i,
  lspp_out_if.source    out_o
);

  lspp_pkg::ctrl_cmd_t  cmd;
  lspp_pkg::dp_status_t status;

  // The enable register takes a write in any cycle.
  assign cfg_i.ready = 1'b1;

  lspp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_enable_i (cfg_i.enable),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  lspp_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .data_byte_i       (in_i.data_byte),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .out_kind_o        (out_o.kind),
    .out_distance_o    (out_o.distance),
    .out_angle_o       (out_o.angle),
    .out_rpm_o         (out_o.rpm),
    .out_rpm_valid_o   (out_o.rpm_valid),
    .out_point_count_o (out_o.point_count),
    .out_last_o        (out_o.last)
  );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Testbench of the lidar scan packet parser: feeds byte and enable words, paces the result
// channel and checks every result word against a predictor of the frame parser.
// Depends on lspp_pkg, the channel interfaces in lspp_if.sv and lidar_scan_packet_parser_unit.

module testbench;
  import lspp_pkg::*;

  localparam int unsigned FRAC          = ANGLE_FRAC_BITS_DEF;
  localparam int unsigned ACC_W         = 16 + FRAC;
  // Longest quiet stretch of the block: the angle step division plus margin.
  localparam int unsigned SETTLE_CYCLES = 15 + FRAC + 16;
  localparam int unsigned RANDOM_BYTES  = 400;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam int unsigned LIMIT_NS      = 2_000_000;

  // Byte positions of the header, ahead of the body positions from the package.
  localparam logic [POS_W-1:0] POS_HUNT   = 10'd0;
  localparam logic [POS_W-1:0] POS_SECOND = 10'd1;
  localparam logic [POS_W-1:0] POS_TYPE   = 10'd2;
  localparam logic [POS_W-1:0] POS_COUNT  = 10'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DIST_W-1:0]  distance;
    logic [ANGLE_W-1:0] angle;
    logic [RPM_W-1:0]   rpm;
    logic               rpm_valid;
    logic [COUNT_W-1:0] point_count;
    logic               last;
  } scan_item_t;

  typedef enum bit {OP_BYTE, OP_ENABLE} stim_op_e;

  typedef struct {
    stim_op_e          op;
    logic [BYTE_W-1:0] value;
    bit                typed;
    scan_item_t        want;
  } stim_row_t;

  // Status words that can be read straight off the frame bytes.
  localparam scan_item_t EMPTY_FRAME_END =
    '{KIND_END_GOOD, 14'd0, 15'd0, 10'd762, 1'b1, 8'd0, 1'b1};
  localparam scan_item_t SINGLE_POINT_END =
    '{KIND_END_BAD, 14'd16383, 15'd32767, 10'd0, 1'b0, 8'd1, 1'b1};

  // Opening sequence: a missed second header byte that must not restart the hunt,
  // an empty frame with the largest rate, a one-sample frame with extreme words and
  // a wrong checksum, and a frame cut short by clearing the enable.
  stim_row_t opening_rows [32] = '{
    '{OP_ENABLE, 8'h01, 1'b0, '0},
    '{OP_BYTE, 8'hAA, 1'b0, '0}, '{OP_BYTE, 8'hAA, 1'b0, '0}, '{OP_BYTE, 8'h55, 1'b0, '0},
    '{OP_BYTE, 8'hAA, 1'b0, '0}, '{OP_BYTE, 8'h55, 1'b0, '0}, '{OP_BYTE, 8'hFF, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0}, '{OP_BYTE, 8'h00, 1'b0, '0}, '{OP_BYTE, 8'h00, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0}, '{OP_BYTE, 8'h00, 1'b0, '0}, '{OP_BYTE, 8'h55, 1'b0, '0},
    '{OP_BYTE, 8'h55, 1'b1, EMPTY_FRAME_END},
    '{OP_BYTE, 8'hAA, 1'b0, '0}, '{OP_BYTE, 8'h55, 1'b0, '0}, '{OP_BYTE, 8'h01, 1'b0, '0},
    '{OP_BYTE, 8'h01, 1'b0, '0}, '{OP_BYTE, 8'hFF, 1'b0, '0}, '{OP_BYTE, 8'hFF, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0}, '{OP_BYTE, 8'h00, 1'b0, '0}, '{OP_BYTE, 8'h00, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0}, '{OP_BYTE, 8'hFF, 1'b0, '0},
    '{OP_BYTE, 8'hFF, 1'b1, SINGLE_POINT_END},
    '{OP_BYTE, 8'hAA, 1'b0, '0}, '{OP_BYTE, 8'h55, 1'b0, '0}, '{OP_BYTE, 8'h03, 1'b0, '0},
    '{OP_ENABLE, 8'h00, 1'b0, '0},
    '{OP_BYTE, 8'hAA, 1'b0, '0},
    '{OP_ENABLE, 8'h01, 1'b0, '0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lspp_cfg_if cfg_if ();
  lspp_in_if  in_if ();
  lspp_out_if out_if ();

  lidar_scan_packet_parser_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted parser state.
  bit                 enabled;
  logic [POS_W-1:0]   frame_pos;
  logic [POS_W-1:0]   bytes_left;
  logic [COUNT_W-1:0] frame_count;
  logic [BYTE_W-1:0]  frame_type;
  logic [BYTE_W-1:0]  low_hold;
  logic [WORD_W-1:0]  xor_sum;
  logic [WORD_W-1:0]  sent_check;
  logic [ANGLE_W-1:0] first_angle;
  logic [ANGLE_W-1:0] last_angle;
  logic [ACC_W-1:0]   angle_inc;
  logic [ACC_W-1:0]   angle_acc;

  scan_item_t  scan_queue[$];
  int unsigned error_count;
  int unsigned result_count;
  int unsigned bytes_taken;
  bit          quiet;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s is %0h, predicted %0h", result_count, name, got, want));
  endtask

  function automatic void restart_frame();
    frame_pos   = POS_HUNT;
    bytes_left  = '0;
    frame_count = '0;
    frame_type  = '0;
    low_hold    = '0;
    xor_sum     = '0;
    sent_check  = '0;
    first_angle = '0;
    last_angle  = '0;
    angle_inc   = '0;
    angle_acc   = '0;
  endfunction

  // Advances the predicted parser by one accepted byte and gives the result word, if any.
  function automatic void parse_byte(input logic [BYTE_W-1:0] b, output bit got,
                                     output scan_item_t item);
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0]  pos;
    int                diff;
    longint unsigned   sum;
    bit                good;
    bit                rv;
    got  = 1'b0;
    item = '0;
    pos  = frame_pos;
    if (!enabled) begin
      frame_pos = POS_HUNT;
      return;
    end

    // Header hunt, type and count.
    if (pos == POS_HUNT) begin
      frame_pos = (b == SYNC_FIRST) ? POS_SECOND : POS_HUNT;
      return;
    end
    if (pos == POS_SECOND) begin
      frame_pos = (b == SYNC_SECOND) ? POS_TYPE : POS_HUNT;
      return;
    end
    if (pos == POS_TYPE) begin
      frame_type = b;
      frame_pos  = POS_COUNT;
      return;
    end
    if (pos == POS_COUNT) begin
      frame_count = b;
      bytes_left  = BODY_FIXED_BYTES + {1'b0, b, 1'b0};
      xor_sum     = HEADER_WORD ^ {b, frame_type};
      frame_pos   = POS_BODY_FIRST;
      return;
    end

    // Body: little-endian words, completed on the odd positions.
    word = {b, low_hold};
    if (!pos[0]) begin
      low_hold = b;
    end else if (pos == POS_START_HI) begin
      first_angle = word[15:1];
      xor_sum ^= word;
    end else if (pos == POS_END_HI) begin
      last_angle = word[15:1];
      xor_sum ^= word;
      diff = int'(last_angle) - int'(first_angle);
      if (diff < 0) diff += int'(FULL_TURN);
      if (diff < 0) diff = 0;
      if (frame_count >= 2) angle_inc = ACC_W'((64'(diff) << FRAC) / 64'(frame_count - 1));
      else angle_inc = '0;
      angle_acc = ACC_W'(64'(first_angle) << FRAC);
    end else if (pos == POS_CHECK_HI) begin
      sent_check = word;
    end else begin
      xor_sum ^= word;
      got           = 1'b1;
      item.kind     = KIND_POINT;
      item.distance = word[15:2];
      item.angle    = angle_acc[FRAC +: ANGLE_W];
      // Step forward, wrapping once past a full turn.
      sum = 64'(angle_acc) + 64'(angle_inc);
      if (sum > (64'(FULL_TURN) << FRAC)) sum -= 64'(FULL_TURN) << FRAC;
      angle_acc = ACC_W'(sum);
    end

    frame_pos  = pos + 1'b1;
    bytes_left = bytes_left - 1'b1;

    // Frame end: the status word, merged with the last point when there is one.
    if (bytes_left == '0) begin
      good             = (xor_sum == sent_check);
      rv               = good && frame_type[RPM_FLAG_BIT];
      got              = 1'b1;
      item.kind        = good ? KIND_END_GOOD : KIND_END_BAD;
      item.rpm         = rv ? RPM_W'(frame_type[7:1]) * RPM_SCALE : '0;
      item.rpm_valid   = rv;
      item.point_count = frame_count;
      item.last        = 1'b1;
      restart_frame();
    end
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one byte word; a typed row replaces the predicted result.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                           input scan_item_t want = '0);
    bit          got;
    scan_item_t  item;
    int unsigned gap;
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (enabled) bytes_taken++;
    parse_byte(b, got, item);
    if (typed) scan_queue.push_back(want);
    else if (got) scan_queue.push_back(item);
    gap = quiet ? 0 : gap_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes the enable once nothing is pending and the division has had time to finish.
  task automatic set_enable(input bit value);
    in_if.valid <= 1'b0;
    while (scan_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid  <= 1'b1;
    cfg_if.enable <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    enabled = value;
    cfg_if.valid <= 1'b0;
  endtask

  // Disables the parser, feeds it a few bytes that it must ignore, and enables it again.
  task automatic drop_link();
    set_enable(1'b0);
    repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
    set_enable(1'b1);
  endtask

  // Mostly an angle inside one turn, sometimes any word at all.
  function automatic logic [WORD_W-1:0] pick_angle_word();
    if ($urandom_range(0, 4) == 0) return WORD_W'($urandom);
    return {ANGLE_W'($urandom_range(0, 23039)), 1'($urandom)};
  endfunction

  // Builds a well-formed frame with random content, mostly with a good checksum,
  // and now and then cuts it off by clearing the enable.
  task automatic send_frame();
    logic [BYTE_W-1:0] type_b;
    logic [BYTE_W-1:0] count;
    logic [WORD_W-1:0] first_w;
    logic [WORD_W-1:0] last_w;
    logic [WORD_W-1:0] check_w;
    logic [WORD_W-1:0] sample;
    logic [BYTE_W-1:0] frame_bytes[$];
    logic [WORD_W-1:0] samples[$];
    int unsigned       cut;
    type_b  = BYTE_W'($urandom);
    count   = ($urandom_range(0, 29) == 0) ? BYTE_W'($urandom_range(200, 255))
                                           : BYTE_W'($urandom_range(0, 12));
    first_w = pick_angle_word();
    last_w  = pick_angle_word();
    check_w = HEADER_WORD ^ {count, type_b} ^ first_w ^ last_w;
    repeat (count) begin
      sample = WORD_W'($urandom);
      samples.push_back(sample);
      check_w ^= sample;
    end
    if ($urandom_range(0, 6) == 0) check_w ^= WORD_W'($urandom_range(1, 65535));
    frame_bytes = '{SYNC_FIRST, SYNC_SECOND, type_b, count, first_w[7:0], first_w[15:8],
                    last_w[7:0], last_w[15:8], check_w[7:0], check_w[15:8]};
    foreach (samples[i]) begin
      frame_bytes.push_back(samples[i][7:0]);
      frame_bytes.push_back(samples[i][15:8]);
    end
    cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, frame_bytes.size() - 1)
                                       : frame_bytes.size();
    for (int i = 0; i < cut; i++) send_byte(frame_bytes[i]);
    if (cut < frame_bytes.size()) drop_link();
  endtask

  // Compares each accepted result word with the oldest prediction.
  task automatic check_result();
    scan_item_t want;
    result_count++;
    if (scan_queue.size() == 0) begin
      report_error($sformatf("result %0d arrived with nothing predicted", result_count));
      return;
    end
    want = scan_queue.pop_front();
    check_field("kind", out_if.kind, want.kind);
    check_field("distance", out_if.distance, want.distance);
    check_field("angle", out_if.angle, want.angle);
    check_field("rpm", out_if.rpm, want.rpm);
    check_field("rpm_valid", out_if.rpm_valid, want.rpm_valid);
    check_field("point_count", out_if.point_count, want.point_count);
    check_field("last", out_if.last, want.last);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) check_result();
  end

  // Result side pacing: runs of ready broken by stalls of random length, no stalls in quiet phases.
  initial begin : result_pacing
    int unsigned span;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      span = quiet ? 16 : $urandom_range(1, 12);
      out_if.ready <= 1'b1;
      repeat (span) @(posedge clk);
      span = quiet ? 0 : gap_len();
      if (span != 0) begin
        out_if.ready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Main stimulus: opening rows, then random phases of frames, noise, broken headers and enable drops.
  initial begin : stimulus
    int unsigned pick;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.enable   <= 1'b0;
    enabled = 1'b0;
    restart_frame();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[i]) begin
      if (opening_rows[i].op == OP_ENABLE) set_enable(opening_rows[i].value[0]);
      else send_byte(opening_rows[i].value, opening_rows[i].typed, opening_rows[i].want);
    end

    bytes_taken = 0;
    while (bytes_taken < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          send_frame();
        end else if (pick < 82) begin
          repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
        end else if (pick < 90) begin
          send_byte(SYNC_FIRST);
          send_byte(BYTE_W'($urandom));
        end else if (pick < 95) begin
          // Truncated frame: its body swallows whatever follows.
          send_byte(SYNC_FIRST);
          send_byte(SYNC_SECOND);
          send_byte(BYTE_W'($urandom));
          send_byte(BYTE_W'($urandom_range(0, 3)));
          repeat ($urandom_range(0, 6)) send_byte(BYTE_W'($urandom));
        end else begin
          drop_link();
        end
      end
    end

    // Drain, then give the block time to show any stray word.
    in_if.valid <= 1'b0;
    while (scan_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a missing result.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
